// ===== design/zrle_pkg.sv =====
// Shared constants, item struct and the run_wrap helper for the zero-run-length byte encoder.
// No dependencies.
package zrle_pkg;

  localparam int DATA_W            = 8;   // width of sample_bits
  localparam int CNT_W             = 4;   // width of bit_count
  localparam int CODE_W            = 8;   // width of code_byte
  localparam int MAX_COUNT         = 15;  // largest value bit_count can carry
  localparam int BITS_PER_ITEM_DEF = 8;

  localparam logic [CODE_W-1:0] RUN_LIMIT = 8'hFF;

  // One input item as it travels from the input register to the lane logic.
  typedef struct packed {
    logic [DATA_W-1:0] sample_bits;
    logic [CNT_W-1:0]  bit_count;
    logic              end_of_shot;
  } zrle_item_t;

  // Run length before a position, folded back once the run has reached 255.
  function automatic logic [CODE_W-1:0] run_wrap(input logic [CODE_W:0] s);
    logic [CODE_W:0] t;
    begin
      t = (s >= {1'b0, RUN_LIMIT}) ? (s - {1'b0, RUN_LIMIT}) : s;
      run_wrap = t[CODE_W-1:0];
    end
  endfunction

endpackage

// ===== design/zrle_lanes.sv =====
// Per-bit lanes of the zero-run-length encoder: one possible code byte per bit
// position plus one for the end-of-shot flush. Uses zrle_pkg.
module zrle_lanes #(
  parameter int BITS_PER_ITEM = zrle_pkg::BITS_PER_ITEM_DEF
) (
  input  zrle_pkg::zrle_item_t            item,
  input  logic [zrle_pkg::CODE_W-1:0]     start_run,
  output logic [((BITS_PER_ITEM < zrle_pkg::MAX_COUNT) ? BITS_PER_ITEM
                 : zrle_pkg::MAX_COUNT):0] emit,
  output logic [zrle_pkg::CODE_W-1:0]     codes [((BITS_PER_ITEM < zrle_pkg::MAX_COUNT)
                                                  ? BITS_PER_ITEM : zrle_pkg::MAX_COUNT)+1],
  output logic [zrle_pkg::CODE_W-1:0]     next_run
);

  localparam int LANES = (BITS_PER_ITEM < zrle_pkg::MAX_COUNT) ? BITS_PER_ITEM
                         : zrle_pkg::MAX_COUNT;
  localparam int POS_W = $clog2(LANES + 1);

  logic [POS_W-1:0]            n_eff;
  logic [LANES-1:0]            bits_ext;
  logic [LANES-1:0]            one_v;
  logic [LANES-1:0]            zero_v;
  logic [POS_W-1:0]            seg_a   [LANES+1];  // position after the last one bit seen
  logic [zrle_pkg::CODE_W:0]   run_a   [LANES+1];  // zeros in the open run, unwrapped
  logic [zrle_pkg::CODE_W-1:0] end_run;

  // Clamp the count; bits above the sample width read as zero.
  always_comb begin
    if (item.bit_count > zrle_pkg::CNT_W'(LANES)) begin
      n_eff = POS_W'(LANES);
    end else begin
      n_eff = POS_W'(item.bit_count);
    end
    for (int k = 0; k < LANES; k++) begin
      bits_ext[k] = (k < zrle_pkg::DATA_W) ? item.sample_bits[k] : 1'b0;
      one_v[k]    = (POS_W'(k) < n_eff) &&  bits_ext[k];
      zero_v[k]   = (POS_W'(k) < n_eff) && !bits_ext[k];
    end
  end

  always_comb begin
    for (int k = 0; k <= LANES; k++) begin
      seg_a[k] = '0;
      for (int j = 0; j < k; j++) begin
        if (one_v[j]) begin
          seg_a[k] = POS_W'(j + 1);
        end
      end
    end
    // Zeros before each bit position; the end slot counts up to n_eff.
    for (int k = 0; k < LANES; k++) begin
      run_a[k] = {1'b0, ((seg_a[k] != '0) ? '0 : start_run)}
                 + (zrle_pkg::CODE_W + 1)'(POS_W'(k) - seg_a[k]);
    end
    run_a[LANES] = {1'b0, ((seg_a[LANES] != '0) ? '0 : start_run)}
                   + (zrle_pkg::CODE_W + 1)'(n_eff - seg_a[LANES]);
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      // A one emits its run; a zero emits 255 when the run reaches the limit here.
      emit[k]  = one_v[k] ||
                 (zero_v[k] && (run_a[k] == (zrle_pkg::CODE_W + 1)'(zrle_pkg::RUN_LIMIT - 1)));
      codes[k] = one_v[k] ? zrle_pkg::run_wrap(run_a[k]) : zrle_pkg::RUN_LIMIT;
    end
    end_run      = zrle_pkg::run_wrap(run_a[LANES]);
    emit[LANES]  = item.end_of_shot;
    codes[LANES] = end_run;
    next_run     = item.end_of_shot ? '0 : end_run;
  end

endmodule

// ===== design/zero_run_length_byte_encoder_core.sv =====
// Zero-run-length byte encoder, top level: input register, lane logic, result bank.
// Uses zrle_pkg and zrle_lanes.
// The first byte of an item is offered once the item has passed the input register
// and been loaded into the result bank, which waits until the bank is free.
// Throughput: one item per cycle while out_ready is high and items give at most one
// byte; an item with more bytes holds the result bank while they leave one per cycle.
// Reset (rst_n, synchronous): clears the valid flags and the zero-run counter.
module zero_run_length_byte_encoder_core #(
  parameter int BITS_PER_ITEM = zrle_pkg::BITS_PER_ITEM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [zrle_pkg::DATA_W-1:0] in_sample_bits,
  input  logic [zrle_pkg::CNT_W-1:0]  in_bit_count,
  input  logic                        in_end_of_shot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [zrle_pkg::CODE_W-1:0] out_code_byte,
  output logic                        out_last_of_item,
  output logic                        out_shot_terminator
);

  // One slot per clamped bit position, plus the flush slot at the top.
  localparam int LANES = (BITS_PER_ITEM < zrle_pkg::MAX_COUNT) ? BITS_PER_ITEM
                         : zrle_pkg::MAX_COUNT;
  localparam int SLOTS = LANES + 1;

  // Input register
  logic                        in_vld_r;
  zrle_pkg::zrle_item_t        item_r;

  // Encoder state: zeros seen since the last emitted byte, always 0..254
  logic [zrle_pkg::CODE_W-1:0] zero_run_r;

  // Result bank: pending bytes of the item in flight, drained lowest slot first
  logic [SLOTS-1:0]            pend_r;
  logic [SLOTS-1:0]            pend_nxt;
  logic [zrle_pkg::CODE_W-1:0] code_r [SLOTS];

  logic [SLOTS-1:0]            lane_emit;
  logic [zrle_pkg::CODE_W-1:0] lane_code [SLOTS];
  logic [zrle_pkg::CODE_W-1:0] run_nxt;

  logic [SLOTS-1:0]            sel_oh;
  logic                        out_fire;
  logic                        bank_free;
  logic                        adv;

  zrle_lanes #(
    .BITS_PER_ITEM (BITS_PER_ITEM)
  ) u_lanes (
    .item      (item_r),
    .start_run (zero_run_r),
    .emit      (lane_emit),
    .codes     (lane_code),
    .next_run  (run_nxt)
  );

  // Lowest pending slot is the next byte out.
  always_comb begin
    sel_oh        = '0;
    out_code_byte = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (pend_r[s]) begin
        sel_oh        = '0;
        sel_oh[s]     = 1'b1;
        out_code_byte = code_r[s];
      end
    end
  end

  assign out_valid           = |pend_r;
  assign out_last_of_item    = ((pend_r & ~sel_oh) == '0);
  assign out_shot_terminator = sel_oh[SLOTS-1];
  assign out_fire            = out_valid && out_ready;

  // The bank takes the next item once it is empty or its last byte leaves now.
  assign bank_free = (pend_r == '0) || (out_fire && out_last_of_item);
  assign adv       = in_vld_r && bank_free;
  assign in_ready  = !in_vld_r || adv;

  always_comb begin
    pend_nxt = pend_r;
    if (out_fire) begin
      pend_nxt = pend_r & ~sel_oh;
    end
    if (adv) begin
      pend_nxt = lane_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      zero_run_r <= '0;
      pend_r     <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        zero_run_r <= run_nxt;
      end
      pend_r <= pend_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.sample_bits <= in_sample_bits;
      item_r.bit_count   <= in_bit_count;
      item_r.end_of_shot <= in_end_of_shot;
    end
    if (adv) begin
      for (int s = 0; s < SLOTS; s++) begin
        code_r[s] <= lane_code[s];
      end
    end
  end

  // The run counter wraps before it can hold the limit.
  a_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    zero_run_r != zrle_pkg::RUN_LIMIT)
    else $error("zero-run counter reached the run limit");

  // Loading a new item never overwrites bytes still pending.
  a_no_byte_lost: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> ((pend_r == '0) || (out_fire && out_last_of_item)))
    else $error("result bank reloaded with bytes pending");

  // The flush byte always closes its item.
  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_shot_terminator) |-> out_last_of_item)
    else $error("terminator byte not last of item");

  // A byte taken leaves the bank on the next cycle unless a new item refills it.
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !adv) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("accepted byte not removed from result bank");

endmodule
